/* sv/pci_interrupt_link_router_assert.svh */
// Concurrent check macros for the link router, sampled on clk_i, off during reset.
`ifndef PCI_INTERRUPT_LINK_ROUTER_ASSERT_SVH
`define PCI_INTERRUPT_LINK_ROUTER_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define PLIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define PLIR_ASSERT_NEVER(lbl, expr, msg) \
  `PLIR_ASSERT(lbl, !(expr), msg)

`endif

/* sv/plir_pkg.sv */
`timescale 1ns / 1ps
package plir_pkg;

  localparam int unsigned NumIrqs = 16;
  localparam int unsigned StepW   = 4;

  localparam logic [7:0]  LinkDis    = 8'h80;
  localparam logic [7:0]  LinkKeep   = 8'h8f;
  localparam logic [15:0] IrqOkMask  = 16'hdef8;
  localparam logic [7:0]  IrqOff     = 8'hff;
  localparam logic [7:0]  IrqCntMax  = 8'hfe;
  localparam logic [15:0] PinCntMax  = 16'hffff;
  localparam logic [7:0]  BadPinIrq  = 8'hff;

  localparam logic [2:0] MODE_READ  = 3'd0;
  localparam logic [2:0] MODE_WRITE = 3'd1;
  localparam logic [2:0] MODE_RSV   = 3'd2;
  localparam logic [2:0] MODE_USE   = 3'd3;
  localparam logic [2:0] MODE_ALLOC = 3'd4;
  localparam logic [2:0] MODE_QUERY = 3'd5;
  localparam logic [2:0] MODE_COLD  = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOIRQ = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Microcode addresses
  localparam logic [StepW-1:0] S_RW     = 4'd0;
  localparam logic [StepW-1:0] S_IRQ    = 4'd1;
  localparam logic [StepW-1:0] S_QRY    = 4'd2;
  localparam logic [StepW-1:0] S_COLD   = 4'd3;
  localparam logic [StepW-1:0] S_NOP    = 4'd4;
  localparam logic [StepW-1:0] S_PINIT  = 4'd5;
  localparam logic [StepW-1:0] S_PSCAN  = 4'd6;
  localparam logic [StepW-1:0] S_PSEL   = 4'd7;
  localparam logic [StepW-1:0] S_PINC   = 4'd8;
  localparam logic [StepW-1:0] S_IINIT  = 4'd9;
  localparam logic [StepW-1:0] S_ISCAN  = 4'd10;
  localparam logic [StepW-1:0] S_ISEL   = 4'd11;
  localparam logic [StepW-1:0] S_ROUTE  = 4'd12;
  localparam logic [StepW-1:0] S_AFIN   = 4'd13;
  localparam logic [StepW-1:0] S_NOIRQ  = 4'd14;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] pin;
    logic [4:0] irq_number;
    logic [7:0] write_value;
  } item_t;

  typedef struct packed {
    logic [7:0] result_value;
    logic [1:0] status;
    logic       routing_valid;
  } result_t;

  typedef enum logic [3:0] {
    ACT_RW, ACT_IRQ, ACT_QRY, ACT_COLD, ACT_NOP,
    ACT_PINIT, ACT_PSCAN, ACT_PSEL, ACT_PINC,
    ACT_IINIT, ACT_ISCAN, ACT_ISEL, ACT_ROUTE, ACT_AFIN, ACT_NOIRQ
  } act_e;

  typedef enum logic [2:0] {
    C_NEXT, C_END, C_PLOOP, C_ILOOP, C_LINK, C_NOFND
  } cond_e;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [StepW-1:0] target;
  } cword_t;

  typedef struct packed {
    logic run;
    logic fin;
    act_e act;
  } ctrl_t;

  typedef struct packed {
    logic link_off;
    logic ptr_last;
    logic iptr_last;
    logic found;
  } stat_t;

  function automatic logic irq_ok(input logic [3:0] irq);
    return IrqOkMask[irq];
  endfunction

  function automatic logic link_valid(input logic [7:0] r);
    return !r[7] && IrqOkMask[r[3:0]];
  endfunction

  function automatic logic [StepW-1:0] entry(input logic [2:0] mode);
    logic [StepW-1:0] s;
    case (mode)
      MODE_READ, MODE_WRITE: s = S_RW;
      MODE_RSV, MODE_USE:    s = S_IRQ;
      MODE_ALLOC:            s = S_PINIT;
      MODE_QUERY:            s = S_QRY;
      MODE_COLD:             s = S_COLD;
      default:               s = S_NOP;
    endcase
    return s;
  endfunction

  function automatic cword_t ucode(input logic [StepW-1:0] step);
    cword_t w;
    case (step)
      S_RW:    w = '{act: ACT_RW,    cond: C_END,   target: S_RW};
      S_IRQ:   w = '{act: ACT_IRQ,   cond: C_END,   target: S_IRQ};
      S_QRY:   w = '{act: ACT_QRY,   cond: C_END,   target: S_QRY};
      S_COLD:  w = '{act: ACT_COLD,  cond: C_END,   target: S_COLD};
      S_NOP:   w = '{act: ACT_NOP,   cond: C_END,   target: S_NOP};
      S_PINIT: w = '{act: ACT_PINIT, cond: C_NEXT,  target: S_PSCAN};
      S_PSCAN: w = '{act: ACT_PSCAN, cond: C_PLOOP, target: S_PSCAN};
      S_PSEL:  w = '{act: ACT_PSEL,  cond: C_NEXT,  target: S_PINC};
      S_PINC:  w = '{act: ACT_PINC,  cond: C_LINK,  target: S_AFIN};
      S_IINIT: w = '{act: ACT_IINIT, cond: C_NEXT,  target: S_ISCAN};
      S_ISCAN: w = '{act: ACT_ISCAN, cond: C_ILOOP, target: S_ISCAN};
      S_ISEL:  w = '{act: ACT_ISEL,  cond: C_NOFND, target: S_NOIRQ};
      S_ROUTE: w = '{act: ACT_ROUTE, cond: C_NEXT,  target: S_AFIN};
      S_AFIN:  w = '{act: ACT_AFIN,  cond: C_END,   target: S_AFIN};
      S_NOIRQ: w = '{act: ACT_NOIRQ, cond: C_END,   target: S_NOIRQ};
      default: w = '{act: ACT_NOP,   cond: C_END,   target: S_NOP};
    endcase
    return w;
  endfunction

endpackage

/* sv/pci_interrupt_link_router.sv */
// A read, write, query, reserve, use or cold item runs one microcode step;
//   done_o strobes in the cycle after that step.
// Allocate runs NUM_PINS + 4 steps when the chosen link is already set, else NUM_PINS + 23
//   (pin scan, then a 16-entry IRQ count scan; one step fewer when no IRQ is enabled).
// A new item is accepted only while busy is low, once the last step of the one before has run.
// Reset: links read 0x80, all counts clear except non-permitted IRQs, cold flag set.
`timescale 1ns / 1ps
`include "pci_interrupt_link_router_assert.svh"
module pci_interrupt_link_router #(
  parameter int unsigned NUM_PINS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  plir_pkg::item_t   item_i,
  output logic              done_o,
  output plir_pkg::result_t result_o
);

  logic            accept;
  logic            noirq_routed;
  plir_pkg::ctrl_t ctrl;
  plir_pkg::stat_t stat;

  assign accept = start && !busy;

  plir_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .mode_i   (item_i.mode),
    .stat_i   (stat),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  plir_dp #(
    .NUM_PINS (NUM_PINS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

  assign noirq_routed = (result_o.status == plir_pkg::ST_NOIRQ) && result_o.routing_valid;

  `PLIR_ASSERT(a_accept_busy, accept |=> busy, "accepted beat did not raise busy")
  `PLIR_ASSERT(a_done_ends_busy, done_o |-> $fell(busy), "result strobe without end of work")
  `PLIR_ASSERT_NEVER(a_noirq_routed, done_o && noirq_routed, "routed link reported with no IRQ")

endmodule

/* sv/plir_seq.sv */
`timescale 1ns / 1ps
module plir_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [2:0]          mode_i,
  input  plir_pkg::stat_t     stat_i,
  output plir_pkg::ctrl_t     ctrl_o,
  output logic                busy_o
);

  logic [plir_pkg::StepW-1:0] step_q, step_d;
  logic                       busy_q, busy_d;
  plir_pkg::cword_t           word;

  assign word = plir_pkg::ucode(step_q);

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    if (accept_i) begin
      step_d = plir_pkg::entry(mode_i);
      busy_d = 1'b1;
    end else if (busy_q) begin
      case (word.cond)
        plir_pkg::C_NEXT:  step_d = step_q + 4'd1;
        plir_pkg::C_END:   busy_d = 1'b0;
        plir_pkg::C_PLOOP: step_d = stat_i.ptr_last ? step_q + 4'd1 : word.target;
        plir_pkg::C_ILOOP: step_d = stat_i.iptr_last ? step_q + 4'd1 : word.target;
        // skip routing when the link holds anything but the bare disabled value
        plir_pkg::C_LINK:  step_d = stat_i.link_off ? step_q + 4'd1 : word.target;
        plir_pkg::C_NOFND: step_d = stat_i.found ? step_q + 4'd1 : word.target;
        default:           busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= plir_pkg::S_NOP;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

  assign ctrl_o.run = busy_q;
  assign ctrl_o.fin = (word.cond == plir_pkg::C_END);
  assign ctrl_o.act = word.act;
  assign busy_o     = busy_q;

endmodule

/* sv/plir_dp.sv */
`timescale 1ns / 1ps
module plir_dp #(
  parameter int unsigned NUM_PINS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  plir_pkg::item_t   item_i,
  input  plir_pkg::ctrl_t   ctrl_i,
  output plir_pkg::stat_t   stat_o,
  output logic              done_o,
  output plir_pkg::result_t result_o
);

  localparam int unsigned PW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam logic [PW-1:0] PtrLast = PW'(NUM_PINS - 1);
  localparam logic [4:0] PinMax = 5'(NUM_PINS);

  logic [7:0]  link_q [NUM_PINS];
  logic [7:0]  link_d [NUM_PINS];
  logic [15:0] pcnt_q [NUM_PINS];
  logic [15:0] pcnt_d [NUM_PINS];
  logic [7:0]  icnt_q [plir_pkg::NumIrqs];
  logic [7:0]  icnt_d [plir_pkg::NumIrqs];

  logic          cold_q, cold_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [PW-1:0] best_q, best_d;
  logic [15:0]   bcnt_q, bcnt_d;
  logic [3:0]    iptr_q, iptr_d;
  logic [3:0]    bi_q, bi_d;
  logic [7:0]    bic_q, bic_d;
  logic          found_q, found_d;
  logic          done_q;

  plir_pkg::item_t   item_q;
  plir_pkg::result_t res, res_q;

  logic [7:0]  link_rd;
  logic [15:0] pcnt_rd;
  logic [7:0]  icnt_rd;
  logic [7:0]  wr_val;
  logic        pin_ok;
  logic        pin_in_ok;

  assign link_rd   = link_q[ptr_q];
  assign pcnt_rd   = pcnt_q[ptr_q];
  assign icnt_rd   = icnt_q[iptr_q];
  assign wr_val    = item_q.write_value & plir_pkg::LinkKeep;
  assign pin_ok    = (item_q.pin != 4'd0) && ({1'b0, item_q.pin} <= PinMax);
  assign pin_in_ok = (item_i.pin != 4'd0) && ({1'b0, item_i.pin} <= PinMax);

  always_comb begin
    link_d  = link_q;
    pcnt_d  = pcnt_q;
    icnt_d  = icnt_q;
    cold_d  = cold_q;
    ptr_d   = ptr_q;
    best_d  = best_q;
    bcnt_d  = bcnt_q;
    iptr_d  = iptr_q;
    bi_d    = bi_q;
    bic_d   = bic_q;
    found_d = found_q;
    res     = '0;
    if (accept_i) begin
      // park the pointer on entry zero for a bad pin so it never leaves the array
      ptr_d  = pin_in_ok ? PW'(item_i.pin - 4'd1) : '0;
      iptr_d = item_i.irq_number[3:0];
    end else if (ctrl_i.run) begin
      case (ctrl_i.act)
        plir_pkg::ACT_RW: begin
          if (!pin_ok) begin
            res.result_value = plir_pkg::LinkDis;
            res.status       = plir_pkg::ST_RANGE;
          end else if (item_q.mode == plir_pkg::MODE_WRITE) begin
            link_d[ptr_q]     = wr_val;
            res.result_value  = wr_val;
            res.routing_valid = plir_pkg::link_valid(wr_val);
          end else begin
            res.result_value  = link_rd;
            res.routing_valid = plir_pkg::link_valid(link_rd);
          end
        end
        plir_pkg::ACT_IRQ: begin
          if (item_q.irq_number[4]) begin
            res.status = plir_pkg::ST_RANGE;
          end else if (cold_q) begin
            if (item_q.mode == plir_pkg::MODE_RSV) begin
              if (icnt_rd == 8'd0 || icnt_rd == plir_pkg::IrqOff) begin
                icnt_d[iptr_q] = plir_pkg::IrqOff;
              end
            end else if (icnt_rd != plir_pkg::IrqOff && icnt_rd < plir_pkg::IrqCntMax) begin
              icnt_d[iptr_q] = icnt_rd + 8'd1;
            end
          end
        end
        plir_pkg::ACT_QRY: begin
          if (!pin_ok) begin
            res.result_value = plir_pkg::BadPinIrq;
            res.status       = plir_pkg::ST_RANGE;
          end else begin
            res.result_value  = {4'd0, link_rd[3:0]};
            res.routing_valid = plir_pkg::link_valid(link_rd);
          end
        end
        plir_pkg::ACT_COLD: cold_d = 1'b1;
        plir_pkg::ACT_NOP: ;
        plir_pkg::ACT_PINIT: begin
          cold_d = 1'b0;
          ptr_d  = '0;
        end
        plir_pkg::ACT_PSCAN: begin
          // strict less-than keeps the lowest pin on ties
          if (ptr_q == '0 || pcnt_rd < bcnt_q) begin
            best_d = ptr_q;
            bcnt_d = pcnt_rd;
          end
          if (ptr_q != PtrLast) begin
            ptr_d = ptr_q + 1'b1;
          end
        end
        plir_pkg::ACT_PSEL: ptr_d = best_q;
        plir_pkg::ACT_PINC: begin
          if (pcnt_rd != plir_pkg::PinCntMax) begin
            pcnt_d[ptr_q] = pcnt_rd + 16'd1;
          end
        end
        plir_pkg::ACT_IINIT: begin
          iptr_d  = 4'd0;
          found_d = 1'b0;
        end
        plir_pkg::ACT_ISCAN: begin
          if (icnt_rd != plir_pkg::IrqOff && (!found_q || icnt_rd < bic_q)) begin
            bi_d    = iptr_q;
            bic_d   = icnt_rd;
            found_d = 1'b1;
          end
          iptr_d = iptr_q + 4'd1;
        end
        plir_pkg::ACT_ISEL: iptr_d = bi_q;
        plir_pkg::ACT_ROUTE: begin
          if (icnt_rd < plir_pkg::IrqCntMax) begin
            icnt_d[iptr_q] = icnt_rd + 8'd1;
          end
          link_d[ptr_q] = {4'd0, iptr_q};
        end
        plir_pkg::ACT_AFIN: begin
          res.result_value  = 8'(ptr_q) + 8'd1;
          res.routing_valid = plir_pkg::link_valid(link_rd);
        end
        plir_pkg::ACT_NOIRQ: res.status = plir_pkg::ST_NOIRQ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PINS; i++) begin
        link_q[i] <= plir_pkg::LinkDis;
        pcnt_q[i] <= 16'd0;
      end
      for (int i = 0; i < plir_pkg::NumIrqs; i++) begin
        icnt_q[i] <= plir_pkg::irq_ok(4'(i)) ? 8'd0 : plir_pkg::IrqOff;
      end
      cold_q  <= 1'b1;
      ptr_q   <= '0;
      best_q  <= '0;
      bcnt_q  <= 16'd0;
      iptr_q  <= 4'd0;
      bi_q    <= 4'd0;
      bic_q   <= 8'd0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      link_q  <= link_d;
      pcnt_q  <= pcnt_d;
      icnt_q  <= icnt_d;
      cold_q  <= cold_d;
      ptr_q   <= ptr_d;
      best_q  <= best_d;
      bcnt_q  <= bcnt_d;
      iptr_q  <= iptr_d;
      bi_q    <= bi_d;
      bic_q   <= bic_d;
      found_q <= found_d;
      done_q  <= ctrl_i.run && ctrl_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
    if (ctrl_i.run && ctrl_i.fin) begin
      res_q <= res;
    end
  end

  assign stat_o.link_off  = (link_rd == plir_pkg::LinkDis);
  assign stat_o.ptr_last  = (ptr_q == PtrLast);
  assign stat_o.iptr_last = (iptr_q == 4'hf);
  assign stat_o.found     = found_q;

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

/* tb/sv/tb_pci_interrupt_link_router.sv */
`timescale 1ns / 1ps
module tb_pci_interrupt_link_router;
  import plir_pkg::*;

  localparam int unsigned NPINS       = 8;
  localparam logic [2:0]  MODE_SPARE  = 3'd7;
  localparam int unsigned TargetItems = 900;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned HammerCount = 260;

  class pirq_tracker;
    logic [7:0]  link_reg [NPINS];
    logic [15:0] pin_cnt [NPINS];
    logic [7:0]  irq_cnt [NumIrqs];
    logic        cold;
    result_t     expected_replies[$];
    int unsigned bad_replies;

    function new();
      for (int i = 0; i < NPINS; i++) begin
        link_reg[i] = LinkDis;
        pin_cnt[i]  = '0;
      end
      for (int i = 0; i < NumIrqs; i++) irq_cnt[i] = IrqOkMask[i] ? 8'h00 : IrqOff;
      cold        = 1'b1;
      bad_replies = 0;
    endfunction

    function logic routes_ok(logic [7:0] r);
      return !r[7] && IrqOkMask[r[3:0]];
    endfunction

    // Advance the shadow state by one beat and return the reply it should produce.
    function result_t route_request(item_t it);
      result_t    r;
      logic       pin_good;
      logic [2:0] p;
      logic [3:0] q;
      int         bp;
      int         bi;
      r        = '0;
      pin_good = (it.pin >= 4'd1) && (it.pin <= NPINS);
      p        = 3'(it.pin - 4'd1);
      q        = it.irq_number[3:0];
      case (it.mode)
        MODE_READ, MODE_WRITE: begin
          if (!pin_good) begin
            r.result_value = LinkDis;
            r.status       = ST_RANGE;
          end else begin
            if (it.mode == MODE_WRITE) link_reg[p] = it.write_value & LinkKeep;
            r.result_value  = link_reg[p];
            r.routing_valid = routes_ok(link_reg[p]);
          end
        end
        MODE_RSV, MODE_USE: begin
          if (it.irq_number >= NumIrqs) begin
            r.status = ST_RANGE;
          end else if (cold) begin
            if (it.mode == MODE_RSV) begin
              if (irq_cnt[q] == 8'h00) irq_cnt[q] = IrqOff;
            end else if (irq_cnt[q] != IrqOff && irq_cnt[q] < IrqCntMax) begin
              irq_cnt[q]++;
            end
          end
        end
        MODE_ALLOC: begin
          cold = 1'b0;
          bp   = 0;
          for (int i = 1; i < NPINS; i++) if (pin_cnt[i] < pin_cnt[bp]) bp = i;
          if (pin_cnt[bp] != PinCntMax) pin_cnt[bp]++;
          bi = 0;
          // Route only a link that still holds the bare disable value.
          if (link_reg[bp] == LinkDis) begin
            bi = -1;
            for (int i = 0; i < NumIrqs; i++)
              if (irq_cnt[i] != IrqOff && (bi < 0 || irq_cnt[i] < irq_cnt[bi])) bi = i;
            if (bi >= 0) begin
              if (irq_cnt[bi] < IrqCntMax) irq_cnt[bi]++;
              link_reg[bp] = 8'(bi);
            end
          end
          if (bi < 0) begin
            r.status = ST_NOIRQ;
          end else begin
            r.result_value  = 8'(bp + 1);
            r.routing_valid = routes_ok(link_reg[bp]);
          end
        end
        MODE_QUERY: begin
          if (!pin_good) begin
            r.result_value = BadPinIrq;
            r.status       = ST_RANGE;
          end else begin
            r.result_value  = {4'h0, link_reg[p][3:0]};
            r.routing_valid = routes_ok(link_reg[p]);
          end
        end
        MODE_COLD: cold = 1'b1;
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(item_t it);
      expected_replies.push_back(route_request(it));
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (expected_replies.size() == 0) begin
        bad_replies++;
        if (bad_replies <= ReportMax)
          $display("ERROR: reply with nothing pending: value %h status %0d valid %0d",
                   got.result_value, got.status, got.routing_valid);
        return;
      end
      want = expected_replies.pop_front();
      if (got.result_value !== want.result_value || got.status !== want.status ||
          got.routing_valid !== want.routing_valid) begin
        bad_replies++;
        if (bad_replies <= ReportMax)
          $display("ERROR: exp value %h status %0d valid %0d, got value %h status %0d valid %0d",
                   want.result_value, want.status, want.routing_valid,
                   got.result_value, got.status, got.routing_valid);
      end
    endfunction
  endclass

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    done_o;
  result_t result_o;

  pirq_tracker tracker = new();
  int unsigned counted_items;
  int unsigned burst_left;

  pci_interrupt_link_router #(
    .NUM_PINS(NPINS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check replies before noting a new beat so a coinciding reply pairs with older work.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tracker.check_reply(result_o);
      if (start && !busy) tracker.note_request(item_i);
    end
  end

  function automatic item_t make_item(logic [2:0] m, logic [3:0] p, logic [4:0] q,
                                      logic [7:0] w);
    item_t it;
    it.mode        = m;
    it.pin         = p;
    it.irq_number  = q;
    it.write_value = w;
    return it;
  endfunction

  function automatic logic [3:0] any_pin();
    int unsigned v;
    if ($urandom_range(0, 9) != 0) return 4'($urandom_range(1, NPINS));
    v = $urandom_range(0, 7);
    return (v == 0) ? 4'd0 : 4'(v + 8);
  endfunction

  function automatic logic [4:0] any_irq();
    if ($urandom_range(0, 9) != 0) return 5'($urandom_range(0, 15));
    return 5'($urandom_range(16, 31));
  endfunction

  function automatic logic [7:0] any_link_value();
    case ($urandom_range(0, 3))
      0, 1:    return LinkDis;
      2:       return 8'($urandom);
      default: return {4'h0, 4'($urandom)};
    endcase
  endfunction

  // Hold start and the beat until accepted; idle between bursts.
  task automatic send_item(input item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    burst_left--;
    if (it.mode != MODE_SPARE) counted_items++;
  endtask

  initial begin
    logic [4:0]  order [16];
    logic [4:0]  tmp;
    int unsigned j;
    int unsigned n;
    int unsigned hot_irq;
    logic        starve;
    start         <= 1'b0;
    item_i        <= '0;
    burst_left    = 0;
    counted_items = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Disabling every IRQ is permanent, so only some seeds take that path.
    starve = ($urandom_range(0, 3) == 0);
    if (starve) begin
      for (int i = 0; i < 16; i++) order[i] = 5'(i);
      for (int i = 15; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < 16; i++) send_item(make_item(MODE_RSV, 4'd0, order[i], 8'h00));
      send_item(make_item(MODE_ALLOC, 4'd0, 5'd0, 8'h00));
      send_item(make_item(MODE_ALLOC, 4'hf, 5'h1f, 8'hff));
    end

    send_item(make_item(MODE_READ,  4'd0,  5'd0,  8'h00));
    send_item(make_item(MODE_WRITE, 4'd15, 5'd31, 8'hff));
    send_item(make_item(MODE_WRITE, 4'd9,  5'd0,  8'h00));
    send_item(make_item(MODE_WRITE, 4'd1,  5'd0,  8'hff));
    send_item(make_item(MODE_WRITE, 4'd8,  5'd0,  8'h05));
    send_item(make_item(MODE_WRITE, 4'd2,  5'd0,  8'h00));
    send_item(make_item(MODE_READ,  4'd1,  5'd0,  8'h00));
    send_item(make_item(MODE_QUERY, 4'd8,  5'd0,  8'h00));
    send_item(make_item(MODE_QUERY, 4'd0,  5'd0,  8'h00));
    send_item(make_item(MODE_QUERY, 4'd15, 5'd0,  8'h00));
    send_item(make_item(MODE_RSV,   4'd0,  5'd16, 8'h00));
    send_item(make_item(MODE_USE,   4'd0,  5'd31, 8'h00));
    send_item(make_item(MODE_RSV,   4'd0,  5'd0,  8'h00));
    send_item(make_item(MODE_RSV,   4'd0,  5'd15, 8'h00));
    send_item(make_item(MODE_USE,   4'd0,  5'd15, 8'h00));
    send_item(make_item(MODE_USE,   4'd0,  5'd3,  8'h00));
    send_item(make_item(MODE_SPARE, 4'hf,  5'h1f, 8'hff));
    send_item(make_item(MODE_ALLOC, 4'd0,  5'd0,  8'h00));
    send_item(make_item(MODE_ALLOC, 4'd0,  5'd0,  8'h00));
    send_item(make_item(MODE_ALLOC, 4'd0,  5'd0,  8'h00));
    send_item(make_item(MODE_USE,   4'd0,  5'd5,  8'h00));
    send_item(make_item(MODE_RSV,   4'd0,  5'd6,  8'h00));
    send_item(make_item(MODE_COLD,  4'd0,  5'd0,  8'h00));
    send_item(make_item(MODE_USE,   4'd0,  5'd5,  8'h00));
    send_item(make_item(MODE_READ,  4'd3,  5'd0,  8'h00));

    // Drive one IRQ count into saturation.
    if (!starve) begin
      do hot_irq = $urandom_range(3, 14); while (!IrqOkMask[hot_irq]);
      send_item(make_item(MODE_COLD, 4'd0, 5'd0, 8'h00));
      repeat (HammerCount) send_item(make_item(MODE_USE, 4'($urandom), 5'(hot_irq),
                                               8'($urandom)));
    end

    while (counted_items < TargetItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(1, 4);
          repeat (n) send_item(make_item(MODE_WRITE, any_pin(), 5'($urandom), any_link_value()));
          if ($urandom_range(0, 1) != 0)
            send_item(make_item(MODE_READ, any_pin(), 5'($urandom), 8'($urandom)));
        end
        3, 4: begin
          send_item(make_item(MODE_COLD, 4'($urandom), 5'($urandom), 8'($urandom)));
          n = $urandom_range(1, 6);
          repeat (n)
            send_item(make_item(($urandom_range(0, 4) == 0) ? MODE_RSV : MODE_USE,
                                4'($urandom), any_irq(), 8'($urandom)));
          n = $urandom_range(1, 3);
          repeat (n) send_item(make_item(MODE_ALLOC, 4'($urandom), 5'($urandom), 8'($urandom)));
        end
        5, 6, 7: begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            send_item(make_item(MODE_ALLOC, 4'($urandom), 5'($urandom), 8'($urandom)));
            if ($urandom_range(0, 1) != 0)
              send_item(make_item(MODE_QUERY, any_pin(), 5'($urandom), 8'($urandom)));
          end
        end
        8: begin
          n = $urandom_range(1, 4);
          repeat (n)
            send_item(make_item(($urandom_range(0, 1) != 0) ? MODE_READ : MODE_QUERY,
                                4'($urandom), 5'($urandom), 8'($urandom)));
        end
        default: begin
          n = $urandom_range(1, 3);
          repeat (n) send_item(make_item(3'($urandom), 4'($urandom), 5'($urandom),
                                         8'($urandom)));
        end
      endcase
    end
    start <= 1'b0;

    while (tracker.expected_replies.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (tracker.bad_replies == 0 && tracker.expected_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
